// File: sv/cvra_pkg.sv
// ----------------------------------------------------------------------------
// Core voltage request arbiter package
// Shared request and result types, codes and voltage constants.
// ----------------------------------------------------------------------------
package cvra_pkg;

    // Request type codes.
    localparam logic [1:0] REQ_VOTE  = 2'd0;
    localparam logic [1:0] REQ_FORCE = 2'd1;
    localparam logic [1:0] REQ_APPLY = 2'd2;

    // Status codes.
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_RANGE   = 2'd1;
    localparam logic [1:0] STS_BLOCKED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_VOLTAGE = 2'd0;
    localparam logic [1:0] REG_MAX_VOLTAGE = 2'd1;
    localparam logic [1:0] REG_DVFS_ON     = 2'd2;

    // Voltage constants in millivolts.
    localparam logic [11:0] BOOT_MV    = 12'd750;
    localparam logic [9:0]  VOTE_RESET = 10'd650;
    localparam logic [9:0]  MIN_LO     = 10'd650;
    localparam logic [9:0]  MIN_HI     = 10'd900;
    localparam logic [9:0]  MAX_LO     = 10'd700;
    localparam logic [9:0]  MAX_HI     = 10'd900;

    // One incoming request.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  requestor;
        logic [11:0] voltage;
        logic        strict_limit;
    } req_t;

    // One result.
    typedef struct packed {
        logic [11:0] target_voltage;
        logic [1:0]  status;
        logic        drive_valid;
        logic [11:0] drive_voltage;
    } res_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [9:0] min_voltage;
        logic [9:0] max_voltage;
        logic       dvfs_on;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic resolve;
    } cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RESOLVE
    } state_t;

endpackage

// File: sv/core_voltage_request_arbiter_core.sv
// ----------------------------------------------------------------------------
// Core voltage request arbiter
// Per-requestor voltage votes, forcing and target application.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// one result: it is captured, then the votes or the forced value are updated,
// then the target is resolved over all votes and registered as the result.
// The result is shown on the result port for exactly one cycle with done
// high, and the receiver cannot stall it, so it must take it then. busy
// drops in that same cycle, so a new request can be taken then, but not while
// one is in flight. Configuration is written through the APB port, which never
// inserts wait states.
module core_voltage_request_arbiter_core
#(
    parameter int NUM_REQUESTORS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cvra_pkg::req_t  request,
    output logic            done,
    output cvra_pkg::res_t  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import cvra_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    // Configuration registers.
    cvra_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request sequencer.
    cvra_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Arbitration datapath.
    cvra_datapath #(
        .NUM_REQUESTORS (NUM_REQUESTORS)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .request (request),
        .result  (result)
    );

endmodule

// File: sv/cvra_regs.sv
// ----------------------------------------------------------------------------
// Core voltage request arbiter register file
// APB-style configuration registers with saturation on write.
// ----------------------------------------------------------------------------
module cvra_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cvra_pkg::cfg_t    cfg
);
    import cvra_pkg::*;

    logic [9:0] min_reg, min_next;
    logic [9:0] max_reg, max_next;
    logic       dvfs_reg, dvfs_next;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic [9:0] wdata10;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign wdata10 = pwdata[9:0];

    // Write decode with saturation of the voltage limits.
    always_comb
    begin
        min_next  = min_reg;
        max_next  = max_reg;
        dvfs_next = dvfs_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_VOLTAGE:
                begin
                    if (wdata10 < MIN_LO)
                        min_next = MIN_LO;
                    else if (wdata10 > MIN_HI)
                        min_next = MIN_HI;
                    else
                        min_next = wdata10;
                end
                REG_MAX_VOLTAGE:
                begin
                    if (wdata10 < MAX_LO)
                        max_next = MAX_LO;
                    else if (wdata10 > MAX_HI)
                        max_next = MAX_HI;
                    else
                        max_next = wdata10;
                end
                REG_DVFS_ON:
                begin
                    dvfs_next = pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_LO;
            max_reg  <= MAX_HI;
            dvfs_reg <= 1'b1;
        end
        else
        begin
            min_reg  <= min_next;
            max_reg  <= max_next;
            dvfs_reg <= dvfs_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            REG_MIN_VOLTAGE: prdata = {22'd0, min_reg};
            REG_MAX_VOLTAGE: prdata = {22'd0, max_reg};
            REG_DVFS_ON:     prdata = {31'd0, dvfs_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.min_voltage = min_reg;
    assign cfg.max_voltage = max_reg;
    assign cfg.dvfs_on     = dvfs_reg;

endmodule

// File: sv/cvra_ctrl.sv
// ----------------------------------------------------------------------------
// Core voltage request arbiter controller
// Sequences capture, state update and target resolution of one request.
// ----------------------------------------------------------------------------
module cvra_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output cvra_pkg::cmd_t cmd
);
    import cvra_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // State register and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        cmd.resolve = 1'b0;
        done_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: sv/cvra_datapath.sv
// ----------------------------------------------------------------------------
// Core voltage request arbiter datapath
// Holds the votes, forced and current voltages and resolves the target.
// ----------------------------------------------------------------------------
module cvra_datapath
#(
    parameter int NUM_REQUESTORS = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cvra_pkg::cmd_t cmd,
    input  cvra_pkg::cfg_t cfg,
    input  cvra_pkg::req_t request,
    output cvra_pkg::res_t result
);
    import cvra_pkg::*;

    req_t        req_reg, req_next;
    logic [9:0]  votes_reg [NUM_REQUESTORS];
    logic [9:0]  votes_next [NUM_REQUESTORS];
    logic [11:0] forced_reg, forced_next;
    logic [11:0] current_reg, current_next;
    logic [1:0]  pstatus_reg, pstatus_next;
    logic        pdvalid_reg, pdvalid_next;
    logic [11:0] pdvolt_reg, pdvolt_next;
    res_t        result_reg, result_next;

    logic [11:0] min12;
    logic [11:0] max12;
    logic [9:0]  vote_sat;
    logic [9:0]  best;
    logic [11:0] target;

    assign min12 = {2'd0, cfg.min_voltage};
    assign max12 = {2'd0, cfg.max_voltage};

    // Clamp of an incoming vote to the configured range.
    always_comb
    begin
        if (req_reg.voltage < min12)
            vote_sat = cfg.min_voltage;
        else if (req_reg.voltage > max12)
            vote_sat = cfg.max_voltage;
        else
            vote_sat = req_reg.voltage[9:0];
    end

    // Target: largest vote, at least the minimum, limited to the maximum,
    // replaced by a nonzero force unless the strict limit is active.
    always_comb
    begin
        best = cfg.min_voltage;
        for (int i = 0; i < NUM_REQUESTORS; i++)
        begin
            if (votes_reg[i] > best)
                best = votes_reg[i];
        end
        if (best < cfg.max_voltage)
            target = {2'd0, best};
        else
            target = max12;
        if ((forced_reg != 12'd0) && !req_reg.strict_limit)
            target = forced_reg;
    end

    // Next state of the datapath.
    always_comb
    begin
        req_next     = req_reg;
        votes_next   = votes_reg;
        forced_next  = forced_reg;
        current_next = current_reg;
        pstatus_next = pstatus_reg;
        pdvalid_next = pdvalid_reg;
        pdvolt_next  = pdvolt_reg;
        result_next  = result_reg;

        if (cmd.capture)
            req_next = request;

        // Vote and force handling.
        if (cmd.update)
        begin
            pstatus_next = STS_OK;
            pdvalid_next = 1'b0;
            pdvolt_next  = 12'd0;
            case (req_reg.req_type)
                REQ_VOTE:
                begin
                    for (int i = 0; i < NUM_REQUESTORS; i++)
                    begin
                        if (req_reg.requestor == 3'(i))
                            votes_next[i] = vote_sat;
                    end
                end
                REQ_FORCE:
                begin
                    if ((req_reg.voltage != 12'd0) &&
                        ((req_reg.voltage > max12) || (req_reg.voltage < min12)))
                        pstatus_next = STS_RANGE;
                    else if (req_reg.strict_limit && (req_reg.voltage != 12'd0))
                        pstatus_next = STS_BLOCKED;
                    else if (cfg.dvfs_on)
                        forced_next = req_reg.voltage;
                    else if (req_reg.voltage == 12'd0)
                    begin
                        forced_next  = 12'd0;
                        pdvalid_next = 1'b1;
                        pdvolt_next  = BOOT_MV;
                    end
                    else
                    begin
                        pdvalid_next = 1'b1;
                        pdvolt_next  = req_reg.voltage;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Resolution and result assembly.
        if (cmd.resolve)
        begin
            result_next.target_voltage = target;
            result_next.status         = pstatus_reg;
            result_next.drive_valid    = pdvalid_reg;
            result_next.drive_voltage  = pdvolt_reg;
            if ((req_reg.req_type == REQ_APPLY) && (target != current_reg))
            begin
                result_next.drive_valid   = 1'b1;
                result_next.drive_voltage = target;
                current_next              = target;
            end
        end
    end

    // Arbiter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REQUESTORS; i++)
                votes_reg[i] <= VOTE_RESET;
            forced_reg  <= 12'd0;
            current_reg <= BOOT_MV;
        end
        else
        begin
            votes_reg   <= votes_next;
            forced_reg  <= forced_next;
            current_reg <= current_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        pstatus_reg <= pstatus_next;
        pdvalid_reg <= pdvalid_next;
        pdvolt_reg  <= pdvolt_next;
        result_reg  <= result_next;
    end

    assign result = result_reg;

endmodule

// File: tb/cvra_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Core voltage request arbiter checker
// Watches the request, result and register ports, predicts every result from
// its own copy of the votes, the forced value and the configuration, and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cvra_checker
#(
    parameter int NUM_REQUESTORS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  cvra_pkg::req_t  request,
    input  logic            done,
    input  cvra_pkg::res_t  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    input  logic [31:0]     prdata,
    input  logic            pready,
    output int              fail_count,
    output int              pending,
    output int              checked_count
);

    import cvra_pkg::*;

    // Shadow configuration, kept at 12 bits to compare against voltages.
    logic [11:0] min_mv;
    logic [11:0] max_mv;
    logic        dvfs_en;

    // Shadow arbiter state.
    logic [11:0] vote_mv [NUM_REQUESTORS];
    logic [11:0] forced_mv;
    logic [11:0] target_mv;
    logic [11:0] core_mv;

    // Results predicted for accepted requests, oldest first.
    res_t expected_results [$];
    int   errors  = 0;
    int   checked = 0;

    function automatic logic [11:0] clamp_mv(input logic [11:0] v, input logic [11:0] lo,
                                             input logic [11:0] hi);
        logic [11:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // The target is the largest vote, raised to the minimum, then capped at the
    // maximum; a live force wins unless the strict limit is active.
    task automatic resolve_target(input logic strict);
        logic [11:0] best;
        best = min_mv;
        for (int i = 0; i < NUM_REQUESTORS; i++)
            if (vote_mv[i] > best)
                best = vote_mv[i];
        target_mv = (best < max_mv) ? best : max_mv;
        if (forced_mv != 12'd0 && !strict)
            target_mv = forced_mv;
    endtask

    // Applies one request to the shadow state and builds its result.
    task automatic arbitrate_request(input req_t r, output res_t o);
        logic [11:0] v;
        v = r.voltage;
        o = '0;
        o.status = STS_OK;
        case (r.req_type)
            REQ_VOTE:
            begin
                if (r.requestor < NUM_REQUESTORS)
                    vote_mv[r.requestor] = clamp_mv(v, min_mv, max_mv);
                resolve_target(r.strict_limit);
            end
            REQ_FORCE:
            begin
                if (v != 12'd0 && (v > max_mv || v < min_mv))
                    o.status = STS_RANGE;
                else if (r.strict_limit && v != 12'd0)
                    o.status = STS_BLOCKED;
                else if (dvfs_en)
                    forced_mv = v;
                else
                begin
                    // With DVFS off the force goes straight to the core, and
                    // a release drives the boot voltage.
                    if (v == 12'd0)
                    begin
                        v = BOOT_MV;
                        forced_mv = 12'd0;
                    end
                    o.drive_valid   = 1'b1;
                    o.drive_voltage = v;
                end
                resolve_target(r.strict_limit);
            end
            REQ_APPLY:
            begin
                resolve_target(r.strict_limit);
                if (target_mv != core_mv)
                begin
                    o.drive_valid   = 1'b1;
                    o.drive_voltage = target_mv;
                    core_mv         = target_mv;
                end
            end
            default:
            begin
                resolve_target(r.strict_limit);
            end
        endcase
        o.target_voltage = target_mv;
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endtask

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        logic [31:0] r;
        case (idx)
            REG_MIN_VOLTAGE: r = {20'd0, min_mv};
            REG_MAX_VOLTAGE: r = {20'd0, max_mv};
            REG_DVFS_ON:     r = {31'd0, dvfs_en};
            default:         r = 32'd0;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t predicted;
        res_t oldest;
        if (!rst_n)
        begin
            min_mv    = {2'b00, MIN_LO};
            max_mv    = {2'b00, MAX_HI};
            dvfs_en   = 1'b1;
            for (int i = 0; i < NUM_REQUESTORS; i++)
                vote_mv[i] = {2'b00, VOTE_RESET};
            forced_mv = 12'd0;
            target_mv = BOOT_MV;
            core_mv   = BOOT_MV;
            expected_results.delete();
            pending       <= 0;
            fail_count    <= errors;
            checked_count <= checked;
        end
        else
        begin
            // Register writes update the shadow configuration, saturated.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MIN_VOLTAGE:
                        min_mv = clamp_mv({2'b00, pwdata[9:0]}, {2'b00, MIN_LO},
                                          {2'b00, MIN_HI});
                    REG_MAX_VOLTAGE:
                        max_mv = clamp_mv({2'b00, pwdata[9:0]}, {2'b00, MAX_LO},
                                          {2'b00, MAX_HI});
                    REG_DVFS_ON:
                        dvfs_en = pwdata[0];
                    default:
                        ;
                endcase
            end

            // Register reads return the stored value.
            if (psel && penable && !pwrite && pready)
                check_field("prdata", register_value(paddr[3:2]), prdata);

            // A result is taken at the edge that ends its strobe cycle.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: target %0d",
                           result.target_voltage);
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("target_voltage", 32'(oldest.target_voltage),
                                32'(result.target_voltage));
                    check_field("status", 32'(oldest.status), 32'(result.status));
                    check_field("drive_valid", 32'(oldest.drive_valid),
                                32'(result.drive_valid));
                    check_field("drive_voltage", 32'(oldest.drive_voltage),
                                32'(result.drive_voltage));
                    checked++;
                end
            end

            // Predict the result of each accepted request.
            if (start && !busy)
            begin
                arbitrate_request(request, predicted);
                expected_results.push_back(predicted);
            end

            pending       <= expected_results.size();
            fail_count    <= errors;
            checked_count <= checked;
        end
    end

endmodule

// File: tb/core_voltage_request_arbiter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Core voltage request arbiter testbench
// Drives directed and random votes, force and apply requests through several
// register settings, with random idle gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module core_voltage_request_arbiter_core_tb;

    import cvra_pkg::*;

    localparam int         NUM_REQUESTORS = 4;
    localparam int         RANDOM_PHASES  = 11;
    localparam int         PHASE_REQUESTS = 150;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    req_t        request = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [31:0] pwdata  = 32'd0;

    logic        busy;
    logic        done;
    res_t        result;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked_count;
    int sent_count;
    int directed_count;
    int setting_count;
    int watchdog;
    bit burst;

    always #10 clk = ~clk;

    core_voltage_request_arbiter_core #(
        .NUM_REQUESTORS(NUM_REQUESTORS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cvra_checker #(
        .NUM_REQUESTORS(NUM_REQUESTORS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // Idle gaps are mostly short, with an occasional long one.
    function automatic int idle_gap();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55)
            gap = 0;
        else if (roll < 88)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        return gap;
    endfunction

    // Random requests stay mostly near the legal voltage window so that
    // votes and forces land on both sides of the configured limits.
    function automatic req_t random_request();
        req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r.req_type = REQ_VOTE;
        else if (roll < 65)
            r.req_type = REQ_FORCE;
        else if (roll < 95)
            r.req_type = REQ_APPLY;
        else
            r.req_type = REQ_UNUSED;
        if ($urandom_range(0, 4) == 0)
            r.requestor = 3'($urandom_range(NUM_REQUESTORS, 7));
        else
            r.requestor = 3'($urandom_range(0, NUM_REQUESTORS - 1));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            r.voltage = 12'd0;
        else if (roll == 1)
            r.voltage = 12'($urandom_range(0, 4095));
        else
            r.voltage = 12'($urandom_range(600, 950));
        r.strict_limit = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    // Holds start high until the request is taken, then idles for a gap.
    task automatic send_request(input req_t r);
        int gap;
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
        gap = idle_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] kind, input logic [2:0] who,
                         input logic [11:0] mv, input logic strict);
        req_t r;
        r.req_type     = kind;
        r.requestor    = who;
        r.voltage      = mv;
        r.strict_limit = strict;
        send_request(r);
        directed_count++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB access: setup cycle, access cycle, then the bus returns to idle.
    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all three registers while idle and reads them back.
    task automatic configure(input logic [31:0] min_word, input logic [31:0] max_word,
                             input logic [31:0] dvfs_word);
        wait_idle();
        apb_access(REG_MIN_VOLTAGE, 1'b1, min_word);
        apb_access(REG_MAX_VOLTAGE, 1'b1, max_word);
        apb_access(REG_DVFS_ON, 1'b1, dvfs_word);
        apb_access(REG_MIN_VOLTAGE, 1'b0, 32'd0);
        apb_access(REG_MAX_VOLTAGE, 1'b0, 32'd0);
        apb_access(REG_DVFS_ON, 1'b0, 32'd0);
        setting_count++;
    endtask

    // Watchdog against a hung handshake.
    initial
    begin
        for (watchdog = 0; watchdog < CYCLE_LIMIT; watchdog++)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [31:0] lo_word;
        logic [31:0] hi_word;
        int          style;
        int          mv;
        sent_count     = 0;
        directed_count = 0;
        setting_count  = 0;
        burst          = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the registers.
        apb_access(REG_MIN_VOLTAGE, 1'b0, 32'd0);
        apb_access(REG_MAX_VOLTAGE, 1'b0, 32'd0);
        apb_access(REG_DVFS_ON, 1'b0, 32'd0);

        // Default limits: vote extremes, an ignored requestor, force paths.
        issue(REQ_VOTE,   3'd0, 12'd4095, 1'b0);
        issue(REQ_VOTE,   3'd1, 12'd0,    1'b1);
        issue(REQ_VOTE,   3'd7, 12'd800,  1'b0);
        issue(REQ_APPLY,  3'd0, 12'd0,    1'b0);
        issue(REQ_FORCE,  3'd0, 12'd800,  1'b0);
        issue(REQ_APPLY,  3'd2, 12'd4095, 1'b0);
        issue(REQ_FORCE,  3'd0, 12'd820,  1'b1);
        issue(REQ_FORCE,  3'd0, 12'd4095, 1'b0);
        issue(REQ_FORCE,  3'd0, 12'd649,  1'b0);
        issue(REQ_VOTE,   3'd3, 12'd700,  1'b1);
        issue(REQ_UNUSED, 3'd5, 12'd900,  1'b0);
        issue(REQ_FORCE,  3'd0, 12'd0,    1'b0);
        issue(REQ_APPLY,  3'd0, 12'd0,    1'b1);

        // DVFS off: forces drive the core directly, release drives boot.
        configure(32'd650, 32'd900, 32'd0);
        issue(REQ_FORCE,  3'd0, 12'd880,  1'b0);
        issue(REQ_FORCE,  3'd0, 12'd0,    1'b1);
        issue(REQ_FORCE,  3'd0, 12'd901,  1'b0);
        issue(REQ_APPLY,  3'd0, 12'd0,    1'b0);

        // Minimum above maximum.
        configure(32'h0000_03FF, 32'd0, 32'd1);
        issue(REQ_VOTE,   3'd2, 12'd650,  1'b0);
        issue(REQ_VOTE,   3'd0, 12'd0,    1'b0);
        issue(REQ_FORCE,  3'd0, 12'd800,  1'b0);
        issue(REQ_FORCE,  3'd0, 12'd0,    1'b0);
        issue(REQ_APPLY,  3'd0, 12'd0,    1'b0);

        // Out-of-bounds writes saturate back to the widest window.
        configure(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(REQ_VOTE,   3'd0, 12'd650,  1'b0);
        issue(REQ_VOTE,   3'd1, 12'd900,  1'b1);
        issue(REQ_APPLY,  3'd0, 12'd0,    1'b0);

        // Random phases, each under its own register setting. Every phase
        // change drains the block first.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            style = phase % 5;
            case (style)
                0:
                begin
                    lo_word = 32'd650;
                    hi_word = 32'd900;
                end
                1:
                begin
                    lo_word = 32'd900;
                    hi_word = 32'd700;
                end
                2:
                begin
                    mv      = $urandom_range(700, 900);
                    lo_word = 32'(mv);
                    hi_word = 32'(mv);
                end
                3:
                begin
                    lo_word = $urandom();
                    hi_word = $urandom();
                end
                default:
                begin
                    lo_word = 32'($urandom_range(600, 950));
                    hi_word = 32'($urandom_range(600, 950));
                end
            endcase
            configure(lo_word, hi_word, ($urandom() & 32'hFFFF_FFFE) | 32'(phase % 2));
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                // Once mid-run, hold off until the block has fully drained.
                if (phase == RANDOM_PHASES / 2 && i == PHASE_REQUESTS / 2)
                    wait_idle();
                send_request(random_request());
            end
            burst = 1'b0;
        end

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Summary: %0d requests (%0d directed) over %0d register settings,",
                 sent_count, directed_count, setting_count);
        $display("         %0d results compared, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
